[hdl/iee_pkg.sv]
// Shared types and codes for the infix expression evaluator.
`timescale 1ns / 1ps
package iee_pkg;
  localparam logic [2:0] OP_PAREN = 3'd0;
  localparam logic [2:0] OP_ADD   = 3'd1;
  localparam logic [2:0] OP_SUB   = 3'd2;
  localparam logic [2:0] OP_MUL   = 3'd3;
  localparam logic [2:0] OP_DIV   = 3'd4;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_OVERFLOW  = 2'd1;
  localparam logic [1:0] ST_MALFORMED = 2'd2;
  localparam logic [1:0] ST_DIVZERO   = 2'd3;

  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_OPEN  = 8'h28;
  localparam logic [7:0] CH_CLOSE = 8'h29;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  // Handshake between sequencer and the shared arithmetic unit
  typedef struct packed {
    logic        start;
    logic [2:0]  op;
    logic [31:0] lhs;
    logic [31:0] rhs;
  } alu_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] result;
  } alu_rsp_t;

  function automatic logic [1:0] prec_of(input logic [2:0] op);
    logic [1:0] p;
    p = 2'd0;
    if (op == OP_ADD || op == OP_SUB) p = 2'd1;
    if (op == OP_MUL || op == OP_DIV) p = 2'd2;
    return p;
  endfunction
endpackage

[hdl/iee_alu.sv]
// Shared arithmetic unit: add, subtract, multiply, radix-2 signed divide.
`timescale 1ns / 1ps
module iee_alu
  import iee_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  alu_req_t req,
  output alu_rsp_t rsp
);
  typedef enum logic [2:0] {
    A_IDLE = 3'b001,
    A_DIV  = 3'b010,
    A_FIN  = 3'b100
  } alu_state_t;

  alu_state_t  state;
  logic [31:0] quot;
  logic [31:0] rem;
  logic [31:0] dvs;
  logic [4:0]  bitn;
  logic        neg;
  logic [32:0] trial;
  logic [31:0] ul;
  logic [31:0] ur;
  logic [31:0] prod;
  logic        quick_op;

  assign ul       = req.lhs[31] ? 32'(0 - req.lhs) : req.lhs;
  assign ur       = req.rhs[31] ? 32'(0 - req.rhs) : req.rhs;
  assign trial    = {rem, quot[31]} - {1'b0, dvs};
  assign prod     = req.lhs * req.rhs;
  assign quick_op = (req.op == OP_ADD) || (req.op == OP_SUB) || (req.op == OP_MUL);

  // Sequence one operation; divide takes one quotient bit a cycle
  always_ff @(posedge clk) begin
    rsp.done <= !rst && ((state == A_IDLE && req.start && quick_op) || state == A_FIN);
    if (rst) begin
      state <= A_IDLE;
    end else begin
      case (state)
        A_IDLE: begin
          if (req.start) begin
            case (req.op)
              OP_ADD: rsp.result <= req.lhs + req.rhs;
              OP_SUB: rsp.result <= req.lhs - req.rhs;
              OP_MUL: rsp.result <= prod;
              default: begin
                quot  <= ul;
                rem   <= 32'd0;
                dvs   <= ur;
                neg   <= req.lhs[31] ^ req.rhs[31];
                bitn  <= 5'd31;
                state <= A_DIV;
              end
            endcase
          end
        end
        A_DIV: begin
          if (!trial[32]) begin
            rem  <= trial[31:0];
            quot <= {quot[30:0], 1'b1};
          end else begin
            rem  <= {rem[30:0], quot[31]};
            quot <= {quot[30:0], 1'b0};
          end
          bitn <= bitn - 5'd1;
          if (bitn == 5'd0) state <= A_FIN;
        end
        A_FIN: begin
          rsp.result <= neg ? 32'(0 - quot) : quot;
          state      <= A_IDLE;
        end
        default: state <= A_IDLE;
      endcase
    end
  end
endmodule

[hdl/infix_expression_evaluator_unit.sv]
// Top level: two-stack infix evaluator with a sequencer around a shared ALU.
// Usage: send one ASCII character a beat on symbol/last (valid/ready). Digits
// push operands, + - * / and parentheses drive precedence reductions, other
// bytes are ignored. The beat with last high unwinds the operator stack and
// yields one result beat on value/status; other beats yield nothing.
// Each character is decoded before the block is ready again; an operator or ')'
// also checks the operator stack, and each reduction it triggers reads both
// operands, runs the ALU and writes back; the divider retires one quotient bit
// per cycle. The final character then passes the end check, the last stack check and the output register.
// The block takes one character at a time and is not ready while it works.
// Reset clears counts, error and result valid; stack memories need no clear.
// When the receiver stalls, the result holds in the output register and the
// block keeps taking characters; a new final result waits until it is taken.
// Status: 0 ok, 1 stack overflow, 2 malformed, 3 divide by zero; value is zero
// unless status is ok.
`timescale 1ns / 1ps
module infix_expression_evaluator_unit
  import iee_pkg::*;
#(
  parameter int STACK_DEPTH = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  symbol,
  input  logic        last,
  output logic        out_valid,
  input  logic        out_ready,
  output logic signed [31:0] value,
  output logic [1:0]  status
);
  localparam int AW = $clog2(STACK_DEPTH);
  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam logic [CW-1:0] FULL = CW'(STACK_DEPTH);

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_DECODE= 9'b000000010,
    S_OPTOP = 9'b000000100,
    S_RD1   = 9'b000001000,
    S_RD2   = 9'b000010000,
    S_ALU   = 9'b000100000,
    S_WAIT  = 9'b001000000,
    S_END   = 9'b010000000,
    S_OUT   = 9'b100000000
  } state_t;

  // mode of the reduction loop
  typedef enum logic [2:0] {
    M_OPER  = 3'b001,
    M_CLOSE = 3'b010,
    M_FINAL = 3'b100
  } mode_t;

  state_t state;
  mode_t  mode;
  logic [31:0] opnd_mem [STACK_DEPTH];
  logic [2:0]  optr_mem [STACK_DEPTH];
  logic [CW-1:0] ocnt;
  logic [CW-1:0] pcnt;
  logic [1:0]  err;
  logic [7:0]  sym;
  logic        lst;
  logic [2:0]  newop;
  logic [2:0]  top;
  logic [31:0] rd;
  logic [31:0] rhs;
  logic [AW-1:0] rd_addr;
  logic [31:0] bottom;
  alu_req_t    req;
  alu_rsp_t    rsp;

  iee_alu u_alu (.clk(clk), .rst(rst), .req(req), .rsp(rsp));

  assign in_ready = (state == S_IDLE);

  // Registered operand read: right operand in S_RD1, left operand in S_RD2
  always_ff @(posedge clk) begin
    rd <= opnd_mem[rd_addr];
  end

  always_comb begin
    rd_addr = AW'(ocnt - CW'(1));
    if (state == S_RD2) rd_addr = AW'(ocnt - CW'(2));
    if (state == S_END) rd_addr = '0;
  end

  // Registered read of the operator on top of the stack
  always_ff @(posedge clk) begin
    top <= optr_mem[AW'(pcnt - CW'(1))];
  end

  // Start the ALU unless the divisor is zero
  always_ff @(posedge clk) begin
    req.start <= !rst && (state == S_ALU) && !(req.op == OP_DIV && rhs == 32'd0);
  end

  // Raise result valid from S_OUT, drop it once the beat is taken
  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (state == S_OUT && (!out_valid || out_ready)) out_valid <= 1'b1;
    else if (out_ready) out_valid <= 1'b0;
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      ocnt      <= '0;
      pcnt      <= '0;
      err       <= ST_OK;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            sym   <= symbol;
            lst   <= last;
            state <= S_DECODE;
          end
        end
        S_DECODE: begin
          state <= lst ? S_END : S_IDLE;
          if (err == ST_OK) begin
            case (sym) inside
              [CH_ZERO:CH_NINE]: begin
                if (ocnt == FULL) err <= ST_OVERFLOW;
                else begin
                  opnd_mem[AW'(ocnt)] <= {24'd0, sym - CH_ZERO};
                  ocnt <= ocnt + CW'(1);
                end
              end
              CH_OPEN: begin
                if (pcnt == FULL) err <= ST_OVERFLOW;
                else begin
                  optr_mem[AW'(pcnt)] <= OP_PAREN;
                  pcnt <= pcnt + CW'(1);
                end
              end
              CH_CLOSE: begin mode <= M_CLOSE; state <= S_OPTOP; end
              CH_PLUS:  begin newop <= OP_ADD; mode <= M_OPER; state <= S_OPTOP; end
              CH_MINUS: begin newop <= OP_SUB; mode <= M_OPER; state <= S_OPTOP; end
              CH_STAR:  begin newop <= OP_MUL; mode <= M_OPER; state <= S_OPTOP; end
              CH_SLASH: begin newop <= OP_DIV; mode <= M_OPER; state <= S_OPTOP; end
              default: ;
            endcase
          end else if (lst) begin
            state <= S_OUT;
          end
        end
        S_OPTOP: begin
          req.op <= top;
          if (err != ST_OK) begin
            state <= lst ? S_END : S_IDLE;
          end else if (mode == M_OPER) begin
            if (pcnt == '0 || top == OP_PAREN || prec_of(top) < prec_of(newop)) begin
              if (pcnt == FULL) err <= ST_OVERFLOW;
              else begin
                optr_mem[AW'(pcnt)] <= newop;
                pcnt <= pcnt + CW'(1);
              end
              state <= lst ? S_END : S_IDLE;
            end else begin
              pcnt <= pcnt - CW'(1);
              state <= S_RD1;
            end
          end else if (pcnt == '0) begin
            if (mode == M_CLOSE) err <= ST_MALFORMED;
            state <= lst ? S_END : S_IDLE;
            if (mode == M_FINAL) state <= S_OUT;
          end else begin
            pcnt <= pcnt - CW'(1);
            if (top == OP_PAREN) begin
              if (mode == M_FINAL) begin err <= ST_MALFORMED; state <= S_OUT; end
              else state <= lst ? S_END : S_IDLE;
            end else state <= S_RD1;
          end
        end
        S_RD1: begin
          if (ocnt < CW'(2)) begin
            err   <= ST_MALFORMED;
            state <= (mode == M_FINAL) ? S_OUT : (lst ? S_END : S_IDLE);
          end else state <= S_RD2;
        end
        S_RD2: begin
          rhs   <= rd;
          state <= S_ALU;
        end
        S_ALU: begin
          if (req.op == OP_DIV && rhs == 32'd0) begin
            err   <= ST_DIVZERO;
            state <= (mode == M_FINAL) ? S_OUT : (lst ? S_END : S_IDLE);
          end else begin
            req.lhs   <= rd;
            req.rhs   <= rhs;
            state     <= S_WAIT;
          end
        end
        S_WAIT: begin
          if (rsp.done) begin
            opnd_mem[AW'(ocnt - CW'(2))] <= rsp.result;
            ocnt  <= ocnt - CW'(1);
            state <= S_OPTOP;
          end
        end
        S_END: begin
          if (err != ST_OK) state <= S_OUT;
          else begin mode <= M_FINAL; state <= S_OPTOP; end
        end
        S_OUT: begin
          if (!out_valid || out_ready) begin
            if (err == ST_OK && ocnt == CW'(1)) begin
              value  <= bottom;
              status <= ST_OK;
            end else begin
              value  <= 32'sd0;
              status <= (err == ST_OK) ? ST_MALFORMED : err;
            end
            ocnt  <= '0;
            pcnt  <= '0;
            err   <= ST_OK;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Bottom operand for the result, captured on the way to S_OUT
  always_ff @(posedge clk) begin
    if (state == S_OPTOP || state == S_END) bottom <= opnd_mem[0];
  end

  // Assertions
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    ocnt <= FULL && pcnt <= FULL) else $error("stack count beyond depth");
  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready) else $error("ready while working");
  a_alu_done: assert property (@(posedge clk) disable iff (rst)
    rsp.done |-> state == S_WAIT) else $error("ALU result with no request");
  a_err_value: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status != ST_OK) |-> value == 32'sd0) else $error("value on error");
endmodule

[sim/tb_infix_expression_evaluator_unit.sv]
// Self-checking testbench for the infix expression evaluator.
`timescale 1ns / 1ps
module tb_infix_expression_evaluator_unit;
  import iee_pkg::*;

  localparam int DEPTH = 64;

  typedef struct packed {
    logic [7:0] sym;
    logic       fin;
  } char_beat_t;

  typedef struct packed {
    logic [31:0] val;
    logic [1:0]  st;
  } eval_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  symbol = 8'd0;
  logic        last = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic signed [31:0] value;
  logic [1:0]  status;

  char_beat_t   pending_chars[$];
  eval_result_t expected_results[$];
  int  mismatches = 0;
  bit  stim_done = 1'b0;
  bit  calm = 1'b0;
  int  send_gap = 0;
  int  recv_gap = 0;

  // Predictor state
  logic [31:0] num_stack[DEPTH];
  logic [2:0]  opr_stack[DEPTH];
  int          num_cnt = 0;
  int          opr_cnt = 0;
  logic [1:0]  err = ST_OK;

  infix_expression_evaluator_unit #(.STACK_DEPTH(DEPTH)) uut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .symbol(symbol), .last(last), .out_valid(out_valid),
    .out_ready(out_ready), .value(value), .status(status)
  );

  always #1 clk = ~clk;

  function automatic int rank(logic [2:0] op);
    if (op == OP_ADD || op == OP_SUB) return 1;
    if (op == OP_MUL || op == OP_DIV) return 2;
    return 0;
  endfunction

  function automatic void flag(logic [1:0] code);
    if (err == ST_OK) err = code;
  endfunction

  function automatic void push_num(logic [31:0] v);
    if (num_cnt >= DEPTH) begin
      flag(ST_OVERFLOW);
      return;
    end
    num_stack[num_cnt] = v;
    num_cnt++;
  endfunction

  function automatic void push_opr(logic [2:0] op);
    if (opr_cnt >= DEPTH) begin
      flag(ST_OVERFLOW);
      return;
    end
    opr_stack[opr_cnt] = op;
    opr_cnt++;
  endfunction

  // Pop right then left, push (left op right)
  function automatic void reduce(logic [2:0] op);
    logic signed [31:0] l, r;
    logic [31:0] v;
    if (num_cnt < 2) begin
      flag(ST_MALFORMED);
      return;
    end
    r = num_stack[num_cnt-1];
    l = num_stack[num_cnt-2];
    case (op)
      OP_ADD: v = l + r;
      OP_SUB: v = l - r;
      OP_MUL: v = l * r;
      OP_DIV: begin
        if (r == 0) begin
          flag(ST_DIVZERO);
          return;
        end
        if (l == 32'sh80000000 && r == -1) v = l;
        else v = l / r;
      end
      default: begin
        flag(ST_MALFORMED);
        return;
      end
    endcase
    num_cnt -= 2;
    push_num(v);
  endfunction

  function automatic void take_char(logic [7:0] c);
    logic [2:0] op;
    logic [2:0] top;
    if (c >= CH_ZERO && c <= CH_NINE) begin
      push_num({24'd0, c - CH_ZERO});
      return;
    end
    if (c == CH_OPEN) begin
      push_opr(OP_PAREN);
      return;
    end
    if (c == CH_CLOSE) begin
      while (err == ST_OK) begin
        if (opr_cnt == 0) begin
          flag(ST_MALFORMED);
          return;
        end
        opr_cnt--;
        if (opr_stack[opr_cnt] == OP_PAREN) return;
        reduce(opr_stack[opr_cnt]);
      end
      return;
    end
    if (c == CH_PLUS) op = OP_ADD;
    else if (c == CH_MINUS) op = OP_SUB;
    else if (c == CH_STAR) op = OP_MUL;
    else if (c == CH_SLASH) op = OP_DIV;
    else return;
    while (err == ST_OK && opr_cnt > 0) begin
      top = opr_stack[opr_cnt-1];
      if (top == OP_PAREN || rank(top) < rank(op)) break;
      opr_cnt--;
      reduce(top);
    end
    if (err == ST_OK) push_opr(op);
  endfunction

  // Advance the predictor by one accepted character
  function automatic void predict_char(char_beat_t b);
    eval_result_t res;
    if (err == ST_OK) take_char(b.sym);
    if (!b.fin) return;
    while (err == ST_OK && opr_cnt > 0) begin
      opr_cnt--;
      if (opr_stack[opr_cnt] == OP_PAREN) flag(ST_MALFORMED);
      else reduce(opr_stack[opr_cnt]);
    end
    if (err == ST_OK && num_cnt != 1) flag(ST_MALFORMED);
    res.val = (err == ST_OK) ? num_stack[0] : 32'd0;
    res.st  = err;
    expected_results.push_back(res);
    num_cnt = 0;
    opr_cnt = 0;
    err = ST_OK;
  endfunction

  task automatic add_expr(string s);
    char_beat_t b;
    for (int i = 0; i < s.len(); i++) begin
      b.sym = s[i];
      b.fin = (i == s.len() - 1);
      pending_chars.push_back(b);
    end
  endtask

  function automatic logic [7:0] rand_digit();
    return CH_ZERO + 8'($urandom_range(0, 9));
  endfunction

  function automatic logic [7:0] rand_oper();
    case ($urandom_range(0, 3))
      0: return CH_PLUS;
      1: return CH_MINUS;
      2: return CH_STAR;
      default: return CH_SLASH;
    endcase
  endfunction

  // Build a well-formed expression of random shape
  function automatic string gen_expr(int lvl);
    string s;
    int terms;
    terms = $urandom_range(1, 4);
    s = "";
    for (int t = 0; t < terms; t++) begin
      if (t > 0) s = {s, string'(rand_oper())};
      if (lvl < 3 && $urandom_range(0, 3) == 0)
        s = {s, "(", gen_expr(lvl + 1), ")"};
      else
        s = {s, string'(rand_digit())};
    end
    return s;
  endfunction

  // Drive the input channel
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      // Stop idling for the last stretch of the run
      if (pending_chars.size() < 150) calm <= 1'b1;
      if (!in_valid || in_ready) begin
        if (in_valid && in_ready) predict_char({symbol, last});
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
          in_valid <= 1'b0;
        end else if (pending_chars.size() > 0) begin
          symbol <= pending_chars[0].sym;
          last   <= pending_chars[0].fin;
          void'(pending_chars.pop_front());
          in_valid <= 1'b1;
          if (!calm && $urandom_range(0, 15) == 0) send_gap <= $urandom_range(1, 19);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Check results and stall the output channel
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Unexpected result value=%h status=%0d", value, status);
        end else if (value !== expected_results[0].val ||
                     status !== expected_results[0].st) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Result mismatch: expected value=%h status=%0d, got value=%h status=%0d",
                     expected_results[0].val, expected_results[0].st, value, status);
          void'(expected_results.pop_front());
        end else begin
          void'(expected_results.pop_front());
        end
      end
      if (recv_gap > 0) begin
        recv_gap  <= recv_gap - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        if (!calm && $urandom_range(0, 7) == 0) recv_gap <= $urandom_range(1, 19);
      end
    end
  end

  initial begin
    string s;
    int n;
    char_beat_t b;
    // Directed expressions: precedence, associativity and each error path
    add_expr("1+2*3");
    add_expr("9-4-3");
    add_expr("8/2/2");
    add_expr("(1+2)*3");
    add_expr("7/0");
    add_expr("0-7/2");
    add_expr("2)");
    add_expr("(2");
    add_expr("12");
    add_expr("+");
    add_expr("*5");
    add_expr("a9 +x1");
    add_expr("((9))");
    add_expr("9/0+)(1");
    // Most negative value over minus one: (0-2)*8^10 / (0-1)
    add_expr("(0-2)*8*8*8*8*8*8*8*8*8*8/(0-1)");
    // Empty expression: one ignored byte marked last
    b.sym = 8'hFF; b.fin = 1'b1; pending_chars.push_back(b);
    // Operand and operator overflow
    s = ""; for (int i = 0; i < DEPTH + 1; i++) s = {s, "9"}; add_expr(s);
    s = ""; for (int i = 0; i < DEPTH + 1; i++) s = {s, "("}; add_expr({s, "1"});
    // Random part: mostly well-formed, some noise and raw bytes
    n = 0;
    while (n < 1330) begin
      if ($urandom_range(0, 9) < 7) begin
        s = gen_expr(0);
        if ($urandom_range(0, 4) == 0) s = {s, " "};
      end else begin
        s = "";
        for (int i = $urandom_range(1, 8); i > 0; i--) begin
          case ($urandom_range(0, 3))
            0: s = {s, string'(8'($urandom_range(1, 255)))};
            1: s = {s, string'(rand_digit())};
            2: s = {s, string'(rand_oper())};
            default: s = {s, ($urandom_range(0, 1) ? "(" : ")")};
          endcase
        end
      end
      add_expr(s);
      n += s.len();
    end
    // Raw zero byte marked last covers the low bits of symbol
    b.sym = 8'h00; b.fin = 1'b1; pending_chars.push_back(b);
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    wait (pending_chars.size() == 0 && !in_valid);
    wait (expected_results.size() == 0);
    repeat (100) @(posedge clk);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Mismatches found");
    $finish;
  end
endmodule
